>>> sv/pfa_pkg.sv
package pfa_pkg;

   typedef enum logic [1:0] {
      FUNC_ALLOC_ONE = 2'd0,
      FUNC_ALLOC_RUN = 2'd1,
      FUNC_FREE_RUN  = 2'd2,
      FUNC_ADD_RANGE = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_SRCH_RD,
      ST_SRCH_WAIT,
      ST_CHK_RD,
      ST_CHK_WAIT,
      ST_UNL_RD,
      ST_UNL_WAIT,
      ST_PUSH,
      ST_DONE
   } state_type;

   localparam int unsigned PAGE_SHIFT = 12;

endpackage

>>> sv/pfa_link_ram.sv
module pfa_link_ram #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12,
   parameter int unsigned DW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/pfa_map_ram.sv
module pfa_map_ram #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          clr_busy
);
   logic          mem [DEPTH];
   logic [AW-1:0] clr_addr_ff;
   logic          clr_busy_ff;

   // clearing pass after reset, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

   assign clr_busy = clr_busy_ff;
endmodule

>>> sv/page_frame_allocator.sv
// channel | ports                                              | direction
// req     | req_valid req_stall req_func req_page_index ...    | in
// rsp     | rsp_valid rsp_stall rsp_got_page rsp_success ...   | out
// one transaction at a time; allocate one reads the list head, pops it and then gives its result
// free and add read the free map and push each page in the range clipped to the store
// allocate run walks the list past unusable entries, checks each page of an aligned
// candidate in the free map, then walks the list again to unlink the run
// after reset the free map is cleared, entry by entry, with req_stall high
// req_stall is high while a transaction is in flight; a waiting result does not block it
module page_frame_allocator #(
   parameter int unsigned NUM_PAGES       = 4096,
   parameter int unsigned ALIGN_PAGES     = 16,
   parameter int unsigned DMA_LIMIT_PAGES = 4096,
   parameter int unsigned MAX_RUN         = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pfa_pkg::func_type       req_func,
   input  logic [11:0]             req_page_index,
   input  logic [12:0]             req_run_length,
   input  logic [24:0]             req_start_addr,
   input  logic [24:0]             req_end_addr,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [11:0]             rsp_got_page,
   output logic                    rsp_success,
   output logic [12:0]             rsp_free_count,
   output logic [12:0]             rsp_used_count
);
   import pfa_pkg::*;

   localparam int unsigned AW = $clog2(NUM_PAGES);
   localparam int unsigned PW = AW + 1;   // page plus null sentinel
   localparam int unsigned CW = 18;       // wide enough for limits up to 65536+256
   localparam logic [PW-1:0] NIL = PW'(NUM_PAGES);
   localparam logic [CW-1:0] NPG = CW'(NUM_PAGES);
   localparam logic [CW-1:0] DMA = CW'(DMA_LIMIT_PAGES);
   localparam logic [CW-1:0] ALN = CW'(ALIGN_PAGES);
   localparam logic [CW-1:0] MXR = CW'(MAX_RUN);

   state_type      state_ff, state_in;
   func_type       func_ff, func_in;
   logic [PW-1:0]  head_ff, head_in;
   logic [PW-1:0]  cur_ff, cur_in;
   logic [PW-1:0]  prev_ff, prev_in;
   logic [CW-1:0]  base_ff, base_in;     // candidate run start / push page
   logic [CW-1:0]  cnt_ff, cnt_in;       // run offset being checked
   logic [CW-1:0]  len_ff, len_in;
   logic [CW-1:0]  lim_ff, lim_in;       // exclusive page limit for free/add
   logic [12:0]    avail_ff, avail_in;
   logic [12:0]    used_ff, used_in;
   logic [11:0]    got_ff, got_in;
   logic           ok_ff, ok_in;
   logic           rv_ff, rv_in;
   logic [11:0]    rpage_ff, rpage_in;
   logic           rok_ff, rok_in;
   logic [12:0]    rfree_ff, rfree_in;
   logic [12:0]    rused_ff, rused_in;

   logic          lk_we, mp_we, mp_wd;
   logic [AW-1:0] lk_wa, lk_ra, mp_wa, mp_ra;
   logic [PW-1:0] lk_wd, lk_rd;
   logic          mp_rd;
   logic          mp_busy;

   pfa_link_ram #(.DEPTH(NUM_PAGES), .AW(AW), .DW(PW)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd)
   );

   pfa_map_ram #(.DEPTH(NUM_PAGES), .AW(AW)) u_map (
      .clock(clock), .reset(reset), .wr_en(mp_we), .wr_addr(mp_wa),
      .wr_data(mp_wd), .rd_addr(mp_ra), .rd_data(mp_rd), .clr_busy(mp_busy)
   );

   logic [CW-1:0] cur_w, sa_pg, ea_pg, pidx_w, run_w;
   logic          aligned;

   always_comb begin
      cur_w   = CW'(cur_ff);
      pidx_w  = CW'(req_page_index);
      run_w   = CW'(req_run_length);
      sa_pg   = CW'((26'(req_start_addr) + 26'd4095) >> PAGE_SHIFT);
      // pages with address below end: ceil(end / page)
      ea_pg   = CW'((26'(req_end_addr) + 26'd4095) >> PAGE_SHIFT);
      aligned = ((cur_w % ALN) == '0);
   end

   always_comb begin
      state_in = state_ff; func_in = func_ff; head_in = head_ff; cur_in = cur_ff;
      prev_in = prev_ff; base_in = base_ff; cnt_in = cnt_ff; len_in = len_ff;
      lim_in = lim_ff; avail_in = avail_ff; used_in = used_ff; got_in = got_ff;
      ok_in = ok_ff; rv_in = rv_ff;
      rpage_in = rpage_ff; rok_in = rok_ff; rfree_in = rfree_ff; rused_in = rused_ff;
      lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = cur_ff[AW-1:0];
      mp_we = 1'b0; mp_wa = '0; mp_wd = 1'b0; mp_ra = cur_ff[AW-1:0];
      req_stall = 1'b1;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = mp_busy;
            if (req_valid && !mp_busy) begin
               func_in = req_func;
               got_in  = '0;
               ok_in   = 1'b1;
               len_in  = run_w;
               cur_in  = head_ff;
               prev_in = NIL;
               case (req_func)
                  FUNC_ALLOC_ONE: begin
                     state_in = ST_POP_RD;
                  end
                  FUNC_ALLOC_RUN: begin
                     ok_in = 1'b0;
                     if (run_w >= CW'(1) && run_w <= MXR) begin
                        state_in = ST_SRCH_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_FREE_RUN: begin
                     base_in  = pidx_w;
                     lim_in   = (pidx_w + run_w < NPG) ? pidx_w + run_w : NPG;
                     cur_in   = '0;
                     state_in = ST_PUSH;
                  end
                  default: begin
                     base_in  = sa_pg;
                     lim_in   = (ea_pg < NPG) ? ea_pg : NPG;
                     cur_in   = '0;
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end
         ST_POP_RD: begin
            if (head_ff >= NIL) begin
               ok_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               lk_ra = head_ff[AW-1:0];
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            got_in  = 12'(head_ff);
            head_in = lk_rd;
            mp_we = 1'b1; mp_wa = head_ff[AW-1:0]; mp_wd = 1'b0;
            if (avail_ff != '0) avail_in = avail_ff - 13'd1;
            if (used_ff < 13'(NUM_PAGES)) used_in = used_ff + 13'd1;
            state_in = ST_DONE;
         end
         ST_SRCH_RD: begin
            if (cur_ff >= NIL) begin
               state_in = ST_DONE;
            end else if (!aligned || cur_w >= DMA || cur_w + len_ff > NPG) begin
               lk_ra = cur_ff[AW-1:0];
               state_in = ST_SRCH_WAIT;
            end else begin
               cnt_in = CW'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_SRCH_WAIT: begin
            cur_in = lk_rd;
            state_in = ST_SRCH_RD;
         end
         ST_CHK_RD: begin
            if (cnt_ff >= len_ff) begin
               ok_in = 1'b1;
               got_in = 12'(cur_ff);
               base_in = cur_w;
               cur_in = head_ff;
               prev_in = NIL;
               state_in = ST_UNL_RD;
            end else begin
               mp_ra = AW'(cur_w + cnt_ff);
               state_in = ST_CHK_WAIT;
            end
         end
         ST_CHK_WAIT: begin
            if (mp_rd) begin
               cnt_in = cnt_ff + CW'(1);
               state_in = ST_CHK_RD;
            end else begin
               lk_ra = cur_ff[AW-1:0];
               state_in = ST_SRCH_WAIT;
            end
         end
         ST_UNL_RD: begin
            if (cur_ff >= NIL) begin
               state_in = ST_DONE;
            end else begin
               lk_ra = cur_ff[AW-1:0];
               state_in = ST_UNL_WAIT;
            end
         end
         ST_UNL_WAIT: begin
            if (cur_w >= base_ff && cur_w < base_ff + len_ff) begin
               if (prev_ff == NIL) begin
                  head_in = lk_rd;
               end else begin
                  lk_we = 1'b1; lk_wa = prev_ff[AW-1:0]; lk_wd = lk_rd;
               end
               mp_we = 1'b1; mp_wa = cur_ff[AW-1:0]; mp_wd = 1'b0;
               if (avail_ff != '0) avail_in = avail_ff - 13'd1;
               if (used_ff < 13'(NUM_PAGES)) used_in = used_ff + 13'd1;
            end else begin
               prev_in = cur_ff;
            end
            cur_in = lk_rd;
            state_in = ST_UNL_RD;
         end
         ST_PUSH: begin
            // per page: read the free map, then push if not yet free
            mp_ra = base_ff[AW-1:0];
            if (base_ff >= lim_ff) begin
               state_in = ST_DONE;
            end else if (!cur_ff[0]) begin
               cur_in = {{(PW-1){1'b0}}, 1'b1};
            end else begin
               cur_in = '0;
               if (!mp_rd) begin
                  lk_we = 1'b1; lk_wa = base_ff[AW-1:0]; lk_wd = head_ff;
                  head_in = PW'(base_ff);
                  mp_we = 1'b1; mp_wa = base_ff[AW-1:0]; mp_wd = 1'b1;
                  avail_in = avail_ff + 13'd1;
                  if (func_ff == FUNC_FREE_RUN && used_ff != '0) begin
                     used_in = used_ff - 13'd1;
                  end
               end
               base_in = base_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               rpage_in = got_ff;
               rok_in   = ok_ff;
               rfree_in = avail_ff;
               rused_in = used_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NIL;
         avail_ff <= '0;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         avail_ff <= avail_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      prev_ff  <= prev_in;
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      len_ff   <= len_in;
      lim_ff   <= lim_in;
      got_ff   <= got_in;
      ok_ff    <= ok_in;
      rpage_ff <= rpage_in;
      rok_ff   <= rok_in;
      rfree_ff <= rfree_in;
      rused_ff <= rused_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_got_page   = rpage_ff;
   assign rsp_success    = rok_ff;
   assign rsp_free_count = rfree_ff;
   assign rsp_used_count = rused_ff;

   a_avail_range: assert property (@(posedge clock) disable iff (reset)
      avail_ff <= 13'(NUM_PAGES)) else $error("free count above page total");
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 13'(NUM_PAGES)) else $error("used count above page total");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (avail_ff == '0 && state_ff == ST_IDLE) |-> head_ff == NIL)
      else $error("list head set with no free pages");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> rv_ff && $stable(rfree_ff) && $stable(rpage_ff))
      else $error("stalled result changed");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

import pfa_pkg::*;

class frame_scoreboard;
   localparam int NPG = 4096;
   localparam int NIL = 4096;
   int unsigned head;
   int unsigned link[NPG];
   bit          is_free[NPG];
   int unsigned avail;
   int unsigned used;
   logic [11:0] exp_page[$];
   logic        exp_ok[$];
   logic [12:0] exp_free[$];
   logic [12:0] exp_used[$];
   int          errors;
   int          checked;

   function new();
      head = NIL;
      avail = 0;
      used = 0;
      errors = 0;
      checked = 0;
      foreach (is_free[i]) is_free[i] = 0;
      foreach (link[i]) link[i] = 0;
   endfunction

   function void push_page(int unsigned q);
      if (q >= NPG || is_free[q]) return;
      link[q] = head;
      head = q;
      is_free[q] = 1;
      avail++;
   endfunction

   function void take_count();
      if (avail > 0) avail--;
      if (used < NPG) used++;
   endfunction

   function bit run_ok(int unsigned x, int unsigned n);
      if (x % 16 != 0 || x >= 4096 || x + n > NPG) return 0;
      for (int unsigned i = 1; i < n; i++)
         if (!is_free[x + i]) return 0;
      return 1;
   endfunction

   function void note_request(func_type f, logic [11:0] pidx, logic [12:0] n,
                              logic [24:0] sa, logic [24:0] ea);
      int unsigned got, x, prev, cur, nxt, q;
      bit ok;
      got = 0;
      ok = 1;
      case (f)
         FUNC_ALLOC_ONE: begin
            if (head < NPG) begin
               got = head;
               head = link[got];
               is_free[got] = 0;
               take_count();
            end else ok = 0;
         end
         FUNC_ALLOC_RUN: begin
            ok = 0;
            x = head;
            if (n >= 1 && n <= 16)
               while (x < NPG) begin
                  if (run_ok(x, n)) begin
                     ok = 1;
                     got = x;
                     break;
                  end
                  x = link[x];
               end
            if (ok) begin
               prev = NIL;
               cur = head;
               while (cur < NPG) begin
                  nxt = link[cur];
                  if (cur >= got && cur < got + n) begin
                     if (prev == NIL) head = nxt;
                     else link[prev] = nxt;
                     is_free[cur] = 0;
                     take_count();
                  end else prev = cur;
                  cur = nxt;
               end
            end
         end
         FUNC_FREE_RUN: begin
            for (int unsigned i = 0; i < n; i++) begin
               q = pidx + i;
               if (q >= NPG) break;
               if (!is_free[q]) begin
                  push_page(q);
                  if (used > 0) used--;
               end
            end
         end
         default: begin
            q = (int'(sa) + 4095) >> PAGE_SHIFT;
            while (q < NPG && (q << PAGE_SHIFT) < ea) begin
               push_page(q);
               q++;
            end
         end
      endcase
      exp_page.push_back(got[11:0]);
      exp_ok.push_back(ok);
      exp_free.push_back(avail[12:0]);
      exp_used.push_back(used[12:0]);
   endfunction

   function int pending();
      return exp_page.size();
   endfunction

   function void check_result(logic [11:0] pg, logic ok, logic [12:0] fc, logic [12:0] uc);
      logic [11:0] e_pg;
      logic        e_ok;
      logic [12:0] e_fc, e_uc;
      if (exp_page.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected transaction: page %0d", pg);
         return;
      end
      e_pg = exp_page.pop_front();
      e_ok = exp_ok.pop_front();
      e_fc = exp_free.pop_front();
      e_uc = exp_used.pop_front();
      checked++;
      if (pg !== e_pg || ok !== e_ok || fc !== e_fc || uc !== e_uc) begin
         errors++;
         if (errors <= 10)
            $display("mismatch #%0d: page %0d/%0d ok %0b/%0b free %0d/%0d used %0d/%0d",
                     checked, e_pg, pg, e_ok, ok, e_fc, fc, e_uc, uc);
      end
   endfunction
endclass

module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   func_type    req_func = FUNC_ALLOC_ONE;
   logic [11:0] req_page_index = 0;
   logic [12:0] req_run_length = 0;
   logic [24:0] req_start_addr = 0;
   logic [24:0] req_end_addr = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [11:0] rsp_got_page;
   logic        rsp_success;
   logic [12:0] rsp_free_count;
   logic [12:0] rsp_used_count;

   frame_scoreboard sb = new();
   bit quiet_rsp = 0;
   bit quiet_req = 0;
   int idle_cycles = 0;
   int n_ops[4] = '{0, 0, 0, 0};
   int run_hits = 0;

   always #5 clock = ~clock;

   page_frame_allocator uut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_success && sb.exp_ok.size() > 0 && sb.exp_ok[0]) run_hits++;
         sb.check_result(rsp_got_page, rsp_success, rsp_free_count, rsp_used_count);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= quiet_rsp ? 1'b0 : ($urandom_range(99) < 7);

   task automatic send(func_type f, logic [11:0] p, logic [12:0] n,
                       logic [24:0] sa, logic [24:0] ea);
      while (!quiet_req && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_page_index <= p;
      req_run_length <= n;
      req_start_addr <= sa;
      req_end_addr <= ea;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(f, p, n, sa, ea);
      n_ops[f]++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_item();
      int k;
      logic [24:0] sa;
      k = $urandom_range(99);
      sa = 25'($urandom);
      if (k < 30)
         send(FUNC_ALLOC_ONE, 12'($urandom), 13'($urandom), 25'($urandom), 25'($urandom));
      else if (k < 55)
         send(FUNC_ALLOC_RUN, 12'($urandom), ($urandom_range(9) == 0) ? 13'($urandom)
              : 13'($urandom_range(16, 1)), 25'($urandom), 25'($urandom));
      else if (k < 85)
         send(FUNC_FREE_RUN,
              ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15, 0) * 16),
              ($urandom_range(19) == 0) ? 13'($urandom) : 13'($urandom_range(40, 1)),
              25'($urandom), 25'($urandom));
      else if ($urandom_range(9) == 0)
         send(FUNC_ADD_RANGE, 12'($urandom), 13'($urandom), sa, 25'($urandom));
      else
         send(FUNC_ADD_RANGE, 12'($urandom), 13'($urandom), sa,
              25'(sa + $urandom_range(200000)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty list first, then extremes
      send(FUNC_ALLOC_ONE, 12'd0, 13'd1, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd1, 25'd0, 25'd0);
      send(FUNC_FREE_RUN, 12'hfff, 13'h1fff, 25'd0, 25'd0);
      send(FUNC_FREE_RUN, 12'd0, 13'd0, 25'd0, 25'd0);
      send(FUNC_ADD_RANGE, 12'd0, 13'd0, 25'h1, 25'h1000);
      send(FUNC_ADD_RANGE, 12'd0, 13'd0, 25'h5000, 25'h3000);
      send(FUNC_ADD_RANGE, 12'd0, 13'd0, 25'h0, 25'h40000);
      send(FUNC_ADD_RANGE, 12'd0, 13'd0, 25'h0, 25'h40000);
      send(FUNC_ADD_RANGE, 12'd0, 13'd0, 25'hfff000, 25'h1ffffff);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd0, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd17, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'h1fff, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd16, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd1, 25'd0, 25'd0);
      send(FUNC_ALLOC_ONE, 12'hfff, 13'h1fff, 25'h1ffffff, 25'h1ffffff);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd16, 25'd0, 25'd0);
      send(FUNC_FREE_RUN, 12'hff0, 13'd16, 25'd0, 25'd0);
      send(FUNC_ALLOC_RUN, 12'd0, 13'd16, 25'd0, 25'd0);
      send(FUNC_FREE_RUN, 12'd0, 13'd4096, 25'd0, 25'd0);
      send(FUNC_FREE_RUN, 12'h555, 13'haaa, 25'h0aaaaaa, 25'h1555555);

      // pressure: sender holds off until everything is back
      drain();

      // no-idle stretch
      quiet_req = 1;
      quiet_rsp = 1;
      repeat (150) random_item();
      quiet_req = 0;
      quiet_rsp = 0;
      drain();

      repeat (1700) random_item();

      drain();
      repeat (400) @(posedge clock);
      $display("covered %0d alloc-one, %0d alloc-run, %0d free-run, %0d add-range",
               n_ops[0], n_ops[1], n_ops[2], n_ops[3]);
      $display("%0d results checked, %0d successful", sb.checked, run_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
sv/pfa_pkg.sv
sv/pfa_link_ram.sv
sv/pfa_map_ram.sv
sv/page_frame_allocator.sv
tb/tb.sv
